// ===== sv/wmqs_pkg.sv =====
// Package for the weighted multilevel queue scheduler.
// Sizes, derived widths and the controller/datapath interface structs.
// No dependencies.
package wmqs_pkg;

    localparam int NUM_LEVELS  = 16;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int BUD_W  = $clog2(NUM_LEVELS + 1);
    localparam int STORE_DEPTH = NUM_LEVELS * (1 << PTR_W);

    localparam int LEVEL_IN_W = 4;
    localparam int ID_IN_W    = 8;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_deq;
    } dp_status_t;

endpackage

// ===== sv/weighted_multilevel_queue_scheduler.sv =====
// An item is registered when taken, then executed once the result register is free; an
// enqueue result is registered in the execute step, a dequeue result after the task
// store's registered read. A new item can be taken during the read-back step.
// Reset (rst_n, async, active low) empties every level FIFO and zeroes budgets;
// the task store is not cleared and needs no clearing pass.
// Top level; depends on wmqs_pkg, wmqs_ctrl, wmqs_dp, wmqs_ram.
module weighted_multilevel_queue_scheduler
    import wmqs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] level, [11:4] task_id, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] granted_id, [11:8] granted_level, [15:12] zero
    output logic [1:0]  m_tuser    // [0] grant_valid, [1] overflow
);

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic                  grant_valid;
    logic [ID_IN_W-1:0]    granted_id;
    logic [LEVEL_IN_W-1:0] granted_level;
    logic                  overflow;

    wmqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wmqs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_cmd        (s_tuser[0]),
        .in_level      (s_tdata[3:0]),
        .in_task_id    (s_tdata[11:4]),
        .grant_valid   (grant_valid),
        .granted_id    (granted_id),
        .granted_level (granted_level),
        .overflow      (overflow)
    );

    assign m_tdata = {4'b0, granted_level, granted_id};
    assign m_tuser = {overflow, grant_valid};

endmodule

// ===== sv/wmqs_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module wmqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wmqs_ctrl.sv =====
// Sequencing controller for the scheduler: input, execute, read-back, output.
// Depends on wmqs_pkg.
module wmqs_ctrl
    import wmqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || (state_reg == S_READ);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = s_tvalid && s_tready;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.is_deq ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = s_tvalid ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if ((cmd.exec && !status.is_deq) || cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> out_free)
        else $error("execute step while result register still occupied");

    a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(cmd.exec && status.is_deq))
        else $error("read-back step without a preceding dequeue");

    a_read_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("read-back would overwrite a pending result");
`endif

endmodule

// ===== sv/wmqs_dp.sv =====
// Scheduler datapath: per-level FIFO pointers, counts, budgets, task store,
// priority select and result register. Depends on wmqs_pkg and wmqs_ram.
module wmqs_dp
    import wmqs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  in_cmd,
    input  logic [LEVEL_IN_W-1:0] in_level,
    input  logic [ID_IN_W-1:0]    in_task_id,
    output logic                  grant_valid,
    output logic [ID_IN_W-1:0]    granted_id,
    output logic [LEVEL_IN_W-1:0] granted_level,
    output logic                  overflow
);

    logic                  cmd_reg;
    logic [LEVEL_IN_W-1:0] level_reg;
    logic [ID_BITS-1:0]    id_reg;

    logic [PTR_W-1:0] head_reg   [NUM_LEVELS];
    logic [PTR_W-1:0] head_next  [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg   [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next  [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] count_next [NUM_LEVELS];
    logic [BUD_W-1:0] budget_reg [NUM_LEVELS];
    logic [BUD_W-1:0] budget_next[NUM_LEVELS];

    logic             gvalid_reg;
    logic [LVL_W-1:0] glevel_reg;

    logic                  out_gvalid_reg;
    logic [ID_IN_W-1:0]    out_id_reg;
    logic [LEVEL_IN_W-1:0] out_level_reg;
    logic                  out_ovf_reg;

    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] ready;
    logic                  ready_any;
    logic                  ne_any;
    logic [LVL_W-1:0]      ready_idx;
    logic [LVL_W-1:0]      ne_idx;
    logic [LVL_W-1:0]      sel;
    logic [LVL_W-1:0]      enq_idx;
    logic [LVL_W-1:0]      idx;
    logic                  lvl_ok;
    logic                  enq_ok;
    logic [CNT_W-1:0]      cnt_at;
    logic [PTR_W-1:0]      ptr_at;
    logic [PTR_W-1:0]      ptr_inc;
    logic [ID_BITS-1:0]    rd_data;
    logic                  ram_we;

    assign status.is_deq = cmd_reg;

    always_comb
    begin
        ready_any = 1'b0;
        ne_any    = 1'b0;
        ready_idx = '0;
        ne_idx    = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            nonempty[i] = (count_reg[i] != '0);
            ready[i]    = nonempty[i] && (budget_reg[i] != '0);
            if (ready[i])
            begin
                ready_any = 1'b1;
                ready_idx = LVL_W'(i);
            end
            if (nonempty[i])
            begin
                ne_any = 1'b1;
                ne_idx = LVL_W'(i);
            end
        end
    end

    // with no ready level, a refill makes every nonempty level ready
    assign sel     = ready_any ? ready_idx : ne_idx;
    assign lvl_ok  = {{(32 - LEVEL_IN_W){1'b0}}, level_reg} < 32'(NUM_LEVELS);
    assign enq_idx = LVL_W'(level_reg);
    assign idx     = (cmd_reg == CMD_DEQ) ? sel : enq_idx;
    assign cnt_at  = count_reg[idx];
    assign ptr_at  = (cmd_reg == CMD_DEQ) ? head_reg[idx] : tail_reg[idx];
    assign ptr_inc = (ptr_at == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr_at + 1'b1;
    assign enq_ok  = lvl_ok && (cnt_at != CNT_W'(LEVEL_DEPTH));
    assign ram_we  = cmd.exec && (cmd_reg == CMD_ENQ) && enq_ok;

    wmqs_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (cmd.exec),
        .we    (ram_we),
        .addr  ({idx, ptr_at}),
        .wdata (id_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]   = head_reg[i];
            tail_next[i]   = tail_reg[i];
            count_next[i]  = count_reg[i];
            budget_next[i] = budget_reg[i];
        end
        if (cmd.exec)
        begin
            if (cmd_reg == CMD_ENQ)
            begin
                if (enq_ok)
                begin
                    tail_next[idx]  = ptr_inc;
                    count_next[idx] = cnt_at + 1'b1;
                end
            end
            else if (ne_any)
            begin
                head_next[idx]  = ptr_inc;
                count_next[idx] = cnt_at - 1'b1;
                if (!ready_any)
                begin
                    for (int i = 0; i < NUM_LEVELS; i++)
                    begin
                        budget_next[i] = BUD_W'(NUM_LEVELS - i);
                    end
                end
                budget_next[idx] = budget_next[idx] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                count_reg[i]  <= '0;
                budget_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]   <= head_next[i];
                tail_reg[i]   <= tail_next[i];
                count_reg[i]  <= count_next[i];
                budget_reg[i] <= budget_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_ENQ;
        end
        else if (cmd.load_in)
        begin
            cmd_reg <= in_cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            level_reg <= in_level;
            id_reg    <= ID_BITS'(in_task_id);
        end
        if (cmd.exec)
        begin
            gvalid_reg <= ne_any;
            glevel_reg <= sel;
        end
        if (cmd.exec && (cmd_reg == CMD_ENQ))
        begin
            out_gvalid_reg <= 1'b0;
            out_id_reg     <= '0;
            out_level_reg  <= '0;
            out_ovf_reg    <= !enq_ok;
        end
        else if (cmd.capture)
        begin
            out_gvalid_reg <= gvalid_reg;
            out_id_reg     <= gvalid_reg ? ID_IN_W'(rd_data) : '0;
            out_level_reg  <= gvalid_reg ? LEVEL_IN_W'(glevel_reg) : '0;
            out_ovf_reg    <= 1'b0;
        end
    end

    assign grant_valid   = out_gvalid_reg;
    assign granted_id    = out_id_reg;
    assign granted_level = out_level_reg;
    assign overflow      = out_ovf_reg;

    logic cnt_bound_ok;
    logic ptr_track_ok;
    logic [CNT_W-1:0] span;

    always_comb
    begin
        cnt_bound_ok = 1'b1;
        ptr_track_ok = 1'b1;
        span         = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (count_reg[i] > CNT_W'(LEVEL_DEPTH))
            begin
                cnt_bound_ok = 1'b0;
            end
            if (tail_reg[i] >= head_reg[i])
            begin
                span = CNT_W'(tail_reg[i]) - CNT_W'(head_reg[i]);
            end
            else
            begin
                span = CNT_W'(tail_reg[i]) + CNT_W'(LEVEL_DEPTH) - CNT_W'(head_reg[i]);
            end
            if (span != ((count_reg[i] == CNT_W'(LEVEL_DEPTH)) ? '0 : count_reg[i]))
            begin
                ptr_track_ok = 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_bound_ok)
        else $error("level count above FIFO depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_track_ok)
        else $error("head/tail pointers disagree with level count");

    a_grant_source: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (cmd_reg == CMD_DEQ) && ne_any) |=> (count_reg[glevel_reg] ==
            $past(cnt_at) - 1'b1))
        else $error("granted level count not decremented");
`endif

endmodule

// ===== verif/weighted_multilevel_queue_scheduler_test.sv =====
// Self-checking testbench for weighted_multilevel_queue_scheduler.
// A directed table, then random enqueue/dequeue traffic with random stalls, checked against
// a per-level FIFO and budget predictor. Depends on wmqs_pkg and the scheduler RTL.
module weighted_multilevel_queue_scheduler_test;
    import wmqs_pkg::*;

    localparam int RANDOM_ITEMS   = 750;
    localparam int CALM_ITEMS     = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic        grant_valid;
        logic [7:0]  granted_id;
        logic [3:0]  granted_level;
        logic        overflow;
    } sched_reply_t;

    typedef struct packed {
        logic         cmd;
        logic [3:0]   level;
        logic [7:0]   task_id;
        logic [4:0]   reps;
        logic         typed;
        sched_reply_t reply;
    } stim_row_t;

    localparam sched_reply_t NO_REPLY  = '{1'b0, 8'h00, 4'd0, 1'b0};
    localparam sched_reply_t DROPPED   = '{1'b0, 8'h00, 4'd0, 1'b1};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [3:0] level, [11:4] task_id, [15:12] zero
    logic [0:0]  s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] granted_id, [11:8] granted_level, [15:12] zero
    logic [1:0]  m_tuser;   // [0] grant_valid, [1] overflow

    // predictor state
    logic [ID_BITS-1:0] fifo_ids   [NUM_LEVELS][LEVEL_DEPTH];
    logic [PTR_W-1:0]   fifo_head  [NUM_LEVELS];
    logic [PTR_W-1:0]   fifo_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]   fifo_count [NUM_LEVELS];
    logic [BUD_W-1:0]   budget     [NUM_LEVELS];

    sched_reply_t replies_due[$];
    int           fail_count = 0;
    int           quiet_cycles = 0;
    bit           calm = 1'b0;

    stim_row_t directed_rows [11] = '{
        '{CMD_DEQ, 4'd0,  8'h00, 5'd1,  1'b1, NO_REPLY},                       // all empty
        '{CMD_ENQ, 4'd0,  8'h00, 5'd1,  1'b1, NO_REPLY},
        '{CMD_ENQ, 4'd15, 8'hFF, 5'd1,  1'b1, NO_REPLY},
        '{CMD_DEQ, 4'd0,  8'h00, 5'd1,  1'b1, '{1'b1, 8'h00, 4'd0,  1'b0}},    // first refill
        '{CMD_DEQ, 4'd0,  8'h00, 5'd1,  1'b1, '{1'b1, 8'hFF, 4'd15, 1'b0}},
        '{CMD_DEQ, 4'd0,  8'h00, 5'd1,  1'b1, NO_REPLY},
        '{CMD_ENQ, 4'd7,  8'h10, 5'd16, 1'b0, NO_REPLY},                       // fill level 7
        '{CMD_ENQ, 4'd7,  8'h5A, 5'd1,  1'b1, DROPPED},                        // full FIFO
        '{CMD_ENQ, 4'd10, 8'hA5, 5'd1,  1'b0, NO_REPLY},
        '{CMD_DEQ, 4'd0,  8'h00, 5'd1,  1'b0, NO_REPLY},
        '{CMD_DEQ, 4'd9,  8'h3C, 5'd1,  1'b0, NO_REPLY}
    };

    weighted_multilevel_queue_scheduler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int first_ready_level();
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (fifo_count[i] != 0 && budget[i] != 0)
                return i;
        end
        return -1;
    endfunction

    function automatic sched_reply_t predict_schedule(logic cmd, logic [3:0] lvl,
                                                      logic [7:0] tid);
        sched_reply_t r;
        int           pick;
        bit           any_queued;
        r = NO_REPLY;
        any_queued = 1'b0;
        if (cmd == CMD_ENQ)
        begin
            if (int'(lvl) >= NUM_LEVELS || int'(fifo_count[lvl]) >= LEVEL_DEPTH)
            begin
                r.overflow = 1'b1;
            end
            else
            begin
                fifo_ids[lvl][fifo_tail[lvl]] = tid[ID_BITS-1:0];
                fifo_tail[lvl] = (int'(fifo_tail[lvl]) == LEVEL_DEPTH - 1) ? '0
                                                                           : fifo_tail[lvl] + 1'b1;
                fifo_count[lvl] = fifo_count[lvl] + 1'b1;
            end
            return r;
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (fifo_count[i] != 0)
                any_queued = 1'b1;
        end
        if (!any_queued)
            return r;
        pick = first_ready_level();
        if (pick < 0)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
                budget[i] = BUD_W'(NUM_LEVELS - i);
            pick = first_ready_level();
        end
        r.grant_valid   = 1'b1;
        r.granted_id    = 8'(fifo_ids[pick][fifo_head[pick]]);
        r.granted_level = 4'(pick);
        fifo_head[pick] = (int'(fifo_head[pick]) == LEVEL_DEPTH - 1) ? '0
                                                                     : fifo_head[pick] + 1'b1;
        fifo_count[pick] = fifo_count[pick] - 1'b1;
        budget[pick]     = budget[pick] - 1'b1;
        return r;
    endfunction

    // Drive one item, wait for the handshake, then record its expected reply.
    task automatic push_item(input logic cmd, input logic [3:0] lvl, input logic [7:0] tid,
                             input logic typed, input sched_reply_t typed_reply);
        sched_reply_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, tid, lvl};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        predicted = predict_schedule(cmd, lvl, tid);
        replies_due.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        if (replies_due.size() != 0)
        begin
            s_tvalid <= 1'b0;
            while (replies_due.size() != 0) @(posedge clk);
        end
    endtask

    initial
    begin
        int           phase;
        int           enq_pct;
        logic         cmd;
        logic [3:0]   lvl;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            fifo_head[i]  = '0;
            fifo_tail[i]  = '0;
            fifo_count[i] = '0;
            budget[i]     = '0;
        end
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < int'(directed_rows[r].reps); k++)
            begin
                push_item(directed_rows[r].cmd, directed_rows[r].level,
                          directed_rows[r].task_id + 8'(k),
                          directed_rows[r].typed, directed_rows[r].reply);
                sender_gap();
            end
        end
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm  = (n >= RANDOM_ITEMS - CALM_ITEMS);
            phase = (n / 60) % 4;
            case (phase)
                0: enq_pct = 75;
                1: enq_pct = 25;
                2: enq_pct = 50;
                default: enq_pct = 80;
            endcase
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if (phase == 3)
                lvl = 4'($urandom_range(0, 2));
            else if ($urandom_range(0, 1) == 0)
                lvl = 4'($urandom_range(0, 3));
            else
                lvl = 4'($urandom_range(0, 15));
            push_item(cmd, lvl, 8'($urandom_range(0, 255)), 1'b0, NO_REPLY);
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            else
                sender_gap();
        end

        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sample at the falling edge: a handshake seen here completes at the next rising edge.
    always @(negedge clk)
    begin
        sched_reply_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("unexpected item: tdata %0h tuser %0h", m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tuser[0] !== want.grant_valid)
                    begin
                        $error("grant_valid: expected %0h, got %0h", want.grant_valid, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== want.granted_id)
                    begin
                        $error("granted_id: expected %0h, got %0h", want.granted_id, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[11:8] !== want.granted_level)
                    begin
                        $error("granted_level: expected %0h, got %0h",
                               want.granted_level, m_tdata[11:8]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.overflow)
                    begin
                        $error("overflow: expected %0h, got %0h", want.overflow, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
